/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the block's RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* hw/rtl/tbdw_pkg.sv */
// ----------------------------------------------------------------------------
// tbdw_pkg
// Types and constants of the whitened TEA block decryptor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tbdw_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned RC_W   = 7;

  localparam logic [31:0] TEA_DELTA = 32'h9e37_79b9;
  localparam int unsigned SHL_AMT   = 4;
  localparam int unsigned SHR_AMT   = 5;

  localparam logic [RC_W-1:0] RC_RESET = 7'd32;

  typedef enum logic [2:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_ROUNDS = 3'd4,
    REG_WHITEN = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] cipher_left;
    logic [31:0] cipher_right;
  } cipher_t;

  typedef struct packed {
    logic [31:0] plain_left;
    logic [31:0] plain_right;
  } plain_t;

  typedef struct packed {
    logic [31:0]     key_word_zero;
    logic [31:0]     key_word_one;
    logic [31:0]     key_word_two;
    logic [31:0]     key_word_three;
    logic [RC_W-1:0] round_count;
    logic            whiten_with_upper;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/tbdw_regs.sv */
// ----------------------------------------------------------------------------
// tbdw_regs
// APB register file: keys, round count, whitening select; clamps round count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbdw_regs
  import tbdw_pkg::*;
#(
  parameter int unsigned MAX_ROUNDS = 64,
  localparam int unsigned RndW = $clog2(MAX_ROUNDS + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output      logic [DATA_W-1:0] prdata,
  output      logic              pready,
  output      cfg_t              cfg_o,
  output      logic [RndW-1:0]   rounds_o
);

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[4:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_KEY0:   cfg_d.key_word_zero     = pwdata;
        REG_KEY1:   cfg_d.key_word_one      = pwdata;
        REG_KEY2:   cfg_d.key_word_two      = pwdata;
        REG_KEY3:   cfg_d.key_word_three    = pwdata;
        REG_ROUNDS: cfg_d.round_count       = pwdata[RC_W-1:0];
        REG_WHITEN: cfg_d.whiten_with_upper = pwdata[0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{key_word_zero: '0, key_word_one: '0, key_word_two: '0,
                 key_word_three: '0, round_count: RC_RESET, whiten_with_upper: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      REG_KEY0:   prdata = cfg_q.key_word_zero;
      REG_KEY1:   prdata = cfg_q.key_word_one;
      REG_KEY2:   prdata = cfg_q.key_word_two;
      REG_KEY3:   prdata = cfg_q.key_word_three;
      REG_ROUNDS: prdata = {{(DATA_W-RC_W){1'b0}}, cfg_q.round_count};
      REG_WHITEN: prdata = {{(DATA_W-1){1'b0}}, cfg_q.whiten_with_upper};
      default:    prdata = '0;
    endcase
  end

  // zero runs one round, large counts saturate
  always_comb begin
    if (cfg_q.round_count == '0) begin
      rounds_o = RndW'(1);
    end else if (32'(cfg_q.round_count) > 32'(MAX_ROUNDS)) begin
      rounds_o = RndW'(MAX_ROUNDS);
    end else begin
      rounds_o = RndW'(cfg_q.round_count);
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hw/rtl/tbdw_ctrl.sv */
// ----------------------------------------------------------------------------
// tbdw_ctrl
// Sequencer: accepts a request, counts rounds, strobes the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tbdw_ctrl
  import tbdw_pkg::*;
#(
  parameter int unsigned MAX_ROUNDS = 64,
  localparam int unsigned RndW = $clog2(MAX_ROUNDS + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  input  wire logic [RndW-1:0] rounds_i,
  output      logic            busy,
  output      logic            result_valid_o,
  output      dp_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ROUND = 3'b010,
    ST_DONE  = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [RndW-1:0] cnt_q, cnt_d;
  logic            accept;

  assign accept = start & (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o.load = 1'b0;
    cmd_o.step = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          cnt_d      = rounds_i;
          state_d    = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q - RndW'(1);
        if (cnt_q == RndW'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_DONE);

  `ASSERT_IMPL(a_load_only_idle, clk_i, rst_ni, cmd_o.load, state_q == ST_IDLE)
  `ASSERT_IMPL(a_step_cnt_live, clk_i, rst_ni, cmd_o.step, cnt_q != '0)
  `ASSERT_NEXT(a_accept_to_round, clk_i, rst_ni, accept, state_q == ST_ROUND)
  `ASSERT_NEXT(a_result_one_cycle, clk_i, rst_ni, result_valid_o,
               !result_valid_o && !busy)

endmodule

`default_nettype wire

/* hw/rtl/tbdw_dp.sv */
// ----------------------------------------------------------------------------
// tbdw_dp
// Datapath: whitening, round sum setup and one TEA decryption round per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbdw_dp
  import tbdw_pkg::*;
#(
  parameter int unsigned MAX_ROUNDS = 64,
  localparam int unsigned RndW = $clog2(MAX_ROUNDS + 1)
) (
  input  wire logic            clk_i,
  input  wire cfg_t            cfg_i,
  input  wire logic [RndW-1:0] rounds_i,
  input  wire dp_cmd_t         cmd_i,
  input  wire cipher_t         cipher_i,
  output      plain_t          plain_o
);

  logic [31:0] left_q, left_d;
  logic [31:0] right_q, right_d;
  logic [31:0] sum_q, sum_d;
  logic [31:0] right_rnd, left_rnd;
  logic [31:0] wk_left, wk_right;

  function automatic logic [31:0] mix_word(input logic [31:0] w, input logic [31:0] ka,
                                           input logic [31:0] kb, input logic [31:0] s);
    mix_word = ((w << SHL_AMT) + ka) ^ (w + s) ^ ((w >> SHR_AMT) + kb);
  endfunction

  assign wk_left  = cfg_i.whiten_with_upper ? cfg_i.key_word_two   : cfg_i.key_word_zero;
  assign wk_right = cfg_i.whiten_with_upper ? cfg_i.key_word_three : cfg_i.key_word_one;

  assign right_rnd = right_q - mix_word(left_q, cfg_i.key_word_two, cfg_i.key_word_three,
                                        sum_q);
  assign left_rnd  = left_q - mix_word(right_rnd, cfg_i.key_word_zero, cfg_i.key_word_one,
                                       sum_q);

  always_comb begin
    left_d  = left_q;
    right_d = right_q;
    sum_d   = sum_q;
    if (cmd_i.load) begin
      left_d  = cipher_i.cipher_left ^ wk_left;
      right_d = cipher_i.cipher_right ^ wk_right;
      sum_d   = 32'(TEA_DELTA * 32'(rounds_i));
    end else if (cmd_i.step) begin
      left_d  = left_rnd;
      right_d = right_rnd;
      sum_d   = sum_q - TEA_DELTA;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q  <= left_d;
    right_q <= right_d;
    sum_q   <= sum_d;
  end

  assign plain_o.plain_left  = left_q;
  assign plain_o.plain_right = right_q;

endmodule

`default_nettype wire

/* hw/rtl/tea_block_decrypt_whitened_unit.sv */
// ----------------------------------------------------------------------------
// tea_block_decrypt_whitened_unit
// Whitened TEA decryption of one 64-bit block per request.
// ----------------------------------------------------------------------------
//  channel  | ports                               | handshake
//  ---------+-------------------------------------+-------------------------
//  request  | cipher_i                            | start & !busy
//  result   | plain_o                             | result_valid_o, 1 cycle
//  config   | psel penable pwrite paddr pwdata    | APB, pready tied high
//
//  One round per cycle in the datapath round loop: a request is loaded on
//  acceptance in idle, steps through its effective rounds in the round state,
//  strobes the result in the done state, and the next is accepted back in idle.
//  busy is high after acceptance through the result cycle.
//  Reset is asynchronous, active low; no clearing pass is needed.
//  The result is flagged for its strobe cycle only; plain_o keeps it until the next load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tea_block_decrypt_whitened_unit
  import tbdw_pkg::*;
#(
  parameter int unsigned MAX_ROUNDS = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output      logic              busy,
  input  wire cipher_t           cipher_i,
  output      logic              result_valid_o,
  output      plain_t            plain_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output      logic [DATA_W-1:0] prdata,
  output      logic              pready
);

  localparam int unsigned RndW = $clog2(MAX_ROUNDS + 1);

  cfg_t            cfg;
  logic [RndW-1:0] rounds;
  dp_cmd_t         cmd;

  tbdw_regs #(.MAX_ROUNDS(MAX_ROUNDS)) u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg_o    (cfg),
    .rounds_o (rounds)
  );

  tbdw_ctrl #(.MAX_ROUNDS(MAX_ROUNDS)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .rounds_i       (rounds),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd)
  );

  tbdw_dp #(.MAX_ROUNDS(MAX_ROUNDS)) u_dp (
    .clk_i    (clk_i),
    .cfg_i    (cfg),
    .rounds_i (rounds),
    .cmd_i    (cmd),
    .cipher_i (cipher_i),
    .plain_o  (plain_o)
  );

endmodule

`default_nettype wire
